### rtl/cdq_pkg.sv
package cdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = IDX_W + 1;

   localparam int CFG_CAP_W  = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_CAP_W-1:0] CAP_RESET = CFG_CAP_W'(16);

   // register index taken from the word address bits
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = '0;

   typedef enum logic [1:0] {
      MODE_PUSH_BACK  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

### rtl/cdq_req_if.sv
interface cdq_req_if
   import cdq_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   mode_type                     mode;
   logic signed [DATA_WIDTH-1:0] push_value;

   modport source (output valid, output mode, output push_value, input ready);
   modport sink   (input valid, input mode, input push_value, output ready);
endinterface

### rtl/cdq_rsp_if.sv
interface cdq_rsp_if
   import cdq_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   status_type                   status;
   logic signed [DATA_WIDTH-1:0] pop_value;
   logic [CNT_W-1:0]             entry_count;

   modport source (output valid, output status, output pop_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input pop_value, input entry_count,
                   output ready);
endinterface

### rtl/cdq_ram.sv
module cdq_ram #(
   parameter int RAM_WIDTH = 32,
   parameter int RAM_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(RAM_DEPTH)-1:0]  wr_addr,
   input  logic [RAM_WIDTH-1:0]          wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(RAM_DEPTH)-1:0]  rd_addr,
   output logic [RAM_WIDTH-1:0]          rd_data
);
   logic [RAM_WIDTH-1:0] mem_ff [RAM_DEPTH];
   logic [RAM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/cdq_ctrl.sv
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] eff_cap,
   cdq_req_if.sink          req,
   cdq_rsp_if.source        rsp
);
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PEND = 2'b10
   } state_type;

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] last;
      last = cap - CNT_W'(1);
      if (idx == '0 || CNT_W'(idx) > last) begin
         return last[IDX_W-1:0];
      end
      return idx - IDX_W'(1);
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   status_type       pend_status_ff, pend_status_in;
   logic             pend_pop_ff, pend_pop_in;
   logic [CNT_W-1:0] pend_count_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  accept;
   logic                  unload;
   logic                  full;
   logic                  empty;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [IDX_W-1:0]      step_idx;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   // output slot is free or drains this cycle
   assign unload    = (state_ff == ST_PEND) && (!rsp_valid_ff || rsp.ready);

   assign full  = (count_ff >= eff_cap);
   assign empty = (count_ff == '0);

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      pend_status_in = STATUS_DONE;
      pend_pop_in    = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = tail_ff;
      rd_en          = 1'b0;
      rd_addr        = head_ff;
      step_idx       = '0;
      case (req.mode)
         MODE_PUSH_BACK: begin
            if (full) begin
               pend_status_in = STATUS_FULL;
            end else begin
               wr_en    = accept;
               wr_addr  = tail_ff;
               tail_in  = step_up(tail_ff, eff_cap);
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_PUSH_FRONT: begin
            if (full) begin
               pend_status_in = STATUS_FULL;
            end else begin
               step_idx = step_down(head_ff, eff_cap);
               wr_en    = accept;
               wr_addr  = step_idx;
               head_in  = step_idx;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               pend_status_in = STATUS_EMPTY;
            end else begin
               rd_en       = accept;
               rd_addr     = head_ff;
               head_in     = step_up(head_ff, eff_cap);
               count_in    = count_ff - CNT_W'(1);
               pend_pop_in = 1'b1;
            end
         end
         default: begin
            if (empty) begin
               pend_status_in = STATUS_EMPTY;
            end else begin
               step_idx    = step_down(tail_ff, eff_cap);
               rd_en       = accept;
               rd_addr     = step_idx;
               tail_in     = step_idx;
               count_in    = count_ff - CNT_W'(1);
               pend_pop_in = 1'b1;
            end
         end
      endcase
      // last entry gone: both ends back to slot zero
      if (pend_pop_in && count_in == '0) begin
         head_in = '0;
         tail_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            if (unload) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (unload) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= pend_status_in;
         pend_pop_ff    <= pend_pop_in;
         pend_count_ff  <= count_in;
      end
      if (unload) begin
         rsp_status_ff <= pend_status_ff;
         rsp_value_ff  <= pend_pop_ff ? rd_data : '0;
         rsp_count_ff  <= pend_count_ff;
      end
   end

   // one item in flight, so a write and a later read of one slot never overlap
   cdq_ram #(
      .RAM_WIDTH (DATA_WIDTH),
      .RAM_DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DATA_WIDTH'(req.push_value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.pop_value   = rsp_value_ff;
   assign rsp.entry_count = rsp_count_ff;
endmodule

### rtl/circular_deque_core.sv
// Double-ended queue in a ring memory. Each request word pushes at the back or
// front or pops from the front or back, and gives exactly one response word with
// a status, the popped value (zero otherwise) and the entry count after the
// operation. The accept cycle updates head, tail and count and issues any ring
// memory access; ST_PEND then moves the registered read word into the output
// register, waiting while that register holds an untaken response until rsp
// ready frees it. The ring needs no clearing after reset; capacity (0 acts as
// 1, above the depth acts as the depth) is written through the csr port at
// address 0; the user must write it only while the queue is idle.
module circular_deque_core
   import cdq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cdq_req_if.sink               req,
   cdq_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   logic [CFG_CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0]     eff_cap;
   logic                 sel_capacity;

   assign csr_pready   = 1'b1;
   assign sel_capacity = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && sel_capacity) begin
         capacity_ff <= csr_pwdata[CFG_CAP_W-1:0];
      end
   end

   assign csr_prdata = sel_capacity ? CSR_DATA_W'(capacity_ff) : '0;

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(capacity_ff) > DEPTH) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   cdq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .eff_cap (eff_cap),
      .req     (req),
      .rsp     (rsp)
   );
endmodule

### sim/cdq_checker.sv
module cdq_checker
   import cdq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cdq_req_if                    req,
   cdq_rsp_if                    rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    error_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type            status;
      logic [DATA_WIDTH-1:0] pop_value;
      logic [CNT_W-1:0]      entry_count;
   } deque_word_type;

   logic [DATA_WIDTH-1:0] ring_copy [DEPTH];
   int unsigned           front_slot;
   int unsigned           back_slot;
   int unsigned           held;
   int unsigned           cap_setting;
   deque_word_type        expected_words [$];

   // capacity as the ring uses it: 0 acts as 1, above the depth acts as the depth
   function automatic int unsigned ring_span();
      if (cap_setting == 0)
         return 1;
      if (cap_setting > DEPTH)
         return DEPTH;
      return cap_setting;
   endfunction

   function automatic int unsigned slot_up(int unsigned idx);
      return (idx + 1 >= ring_span()) ? 0 : idx + 1;
   endfunction

   // a slot left beyond a shrunk ring also steps down to the top slot
   function automatic int unsigned slot_down(int unsigned idx);
      if (idx == 0 || idx > ring_span() - 1)
         return ring_span() - 1;
      return idx - 1;
   endfunction

   task automatic predict_word(input mode_type m, input logic [DATA_WIDTH-1:0] v);
      deque_word_type w;
      w.status    = STATUS_DONE;
      w.pop_value = '0;
      if (m == MODE_PUSH_BACK || m == MODE_PUSH_FRONT) begin
         if (held >= ring_span()) begin
            w.status = STATUS_FULL;
         end else if (m == MODE_PUSH_BACK) begin
            ring_copy[back_slot % DEPTH] = v;
            back_slot = slot_up(back_slot);
            held++;
         end else begin
            front_slot = slot_down(front_slot);
            ring_copy[front_slot % DEPTH] = v;
            held++;
         end
      end else if (held == 0) begin
         w.status = STATUS_EMPTY;
      end else begin
         if (m == MODE_POP_FRONT) begin
            w.pop_value = ring_copy[front_slot % DEPTH];
            front_slot  = slot_up(front_slot);
         end else begin
            back_slot   = slot_down(back_slot);
            w.pop_value = ring_copy[back_slot % DEPTH];
         end
         held--;
         if (held == 0) begin
            front_slot = 0;
            back_slot  = 0;
         end
      end
      w.entry_count = CNT_W'(held);
      expected_words.push_back(w);
   endtask

   always @(posedge clock) begin
      deque_word_type want;
      if (reset) begin
         front_slot  = 0;
         back_slot   = 0;
         held        = 0;
         cap_setting = CAP_RESET;
         expected_words.delete();
      end else begin
         // a response never belongs to the request taken at the same edge
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t unexpected word: expected none, got status %0d value %h count %0d",
                        $time, rsp.status, rsp.pop_value, rsp.entry_count);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp.status !== want.status || rsp.pop_value !== want.pop_value ||
                   rsp.entry_count !== want.entry_count) begin
                  $display({"%0t mismatch: expected status %0d value %h count %0d,",
                            " got status %0d value %h count %0d"},
                           $time, want.status, want.pop_value, want.entry_count,
                           rsp.status, rsp.pop_value, rsp.entry_count);
                  error_count++;
               end
            end
         end
         if (req.valid && req.ready)
            predict_word(req.mode, req.push_value);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY)
            cap_setting = csr_pwdata[CFG_CAP_W-1:0];
      end
      pending_count = expected_words.size();
   end

endmodule

### sim/circular_deque_core_tb.sv
module circular_deque_core_tb;
   import cdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    pending_count;
   int                    snd_idle;
   int                    rcv_idle;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_deque_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cdq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver stalls
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(0, 99) >= rcv_idle);
      end
   end

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input mode_type m, input logic [DATA_WIDTH-1:0] v);
      while ($urandom_range(0, 99) < snd_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.mode       = m;
      req_bus.push_value = v;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   initial begin
      logic [DATA_WIDTH-1:0] fill_words [16];
      int                    cap_plan [9];
      int                    push_bias;
      int                    cap_value;
      mode_type              m;

      fill_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_fffe,
                     32'h8000_0001, 32'h7fff_fffe, 32'h1234_5678, 32'hedcb_a987,
                     32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_ffff, 32'hffff_0000};
      cap_plan   = '{1, 0, 31, 16, 17, 2, 5, 0, 16};
      cap_plan[7] = $urandom_range(1, 16);

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_PUSH_BACK;
      req_bus.push_value = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      snd_idle           = 29;
      rcv_idle           = 75;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pops on an empty queue, then fill every slot so no later read is of an unwritten one
      send_word(MODE_POP_FRONT, $urandom);
      send_word(MODE_POP_BACK, $urandom);
      foreach (fill_words[i])
         send_word(MODE_PUSH_BACK, fill_words[i]);
      send_word(MODE_PUSH_FRONT, 32'h7fff_ffff);
      send_word(MODE_PUSH_BACK, 32'h8000_0000);
      send_word(MODE_POP_FRONT, $urandom);
      send_word(MODE_POP_BACK, $urandom);
      send_word(MODE_PUSH_FRONT, 32'hdead_beef);
      send_word(MODE_POP_BACK, $urandom);

      push_bias = 50;
      for (int seg = 0; seg < 9; seg++) begin
         case (seg / 3)
            0: begin snd_idle = 29; rcv_idle = 75; end
            1: begin snd_idle = 75; rcv_idle = 29; end
            default: begin snd_idle = 0; rcv_idle = 0; end
         endcase
         drain_results();
         cap_value = cap_plan[seg];
         // bits above the capacity field carry junk
         csr_write({REG_CAPACITY, 2'b00}, ($urandom & ~32'h1f) | CSR_DATA_W'(cap_value));
         if (seg == 4)
            csr_write({~REG_CAPACITY, 2'b00}, $urandom);
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               case ($urandom_range(0, 2))
                  0: push_bias = 85;
                  1: push_bias = 50;
                  default: push_bias = 15;
               endcase
            end
            // hold off until the queue has answered everything
            if ($urandom_range(0, 149) == 0)
               drain_results();
            if ($urandom_range(0, 99) < push_bias)
               m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            else
               m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
            send_word(m, pick_value());
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/cdq_pkg.sv
rtl/cdq_req_if.sv
rtl/cdq_rsp_if.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/circular_deque_core.sv
sim/cdq_checker.sv
sim/circular_deque_core_tb.sv
